/* src/image_block_binning_average_unit_macros.svh */
// Assertion macros used by the binning unit controller
`ifndef IMAGE_BLOCK_BINNING_AVERAGE_UNIT_MACROS_SVH
`define IMAGE_BLOCK_BINNING_AVERAGE_UNIT_MACROS_SVH

// same-cycle implication
`define IBBA_ASSERT_IMP(label, c, r, ante, cons) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
        else $error("ibba assertion failed");

// next-cycle implication
`define IBBA_ASSERT_NXT(label, c, r, ante, cons) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
        else $error("ibba assertion failed");

`endif

/* src/ibba_pkg.sv */
// Types and constants shared by the binning unit modules
`default_nettype none

package ibba_pkg;

    localparam int PIX_W        = 16;
    localparam int BIN_W        = 4;
    localparam int CFG_W        = 13;
    localparam int IDX_W        = 2;
    localparam int ROW_CNT_W    = 12;
    localparam int HGT_W        = 13;
    localparam int RX_W         = HGT_W + 1;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int MIN_BIN      = 2;

    localparam logic [IDX_W-1:0] REG_BIN_FACTOR   = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic [BIN_W-1:0] RST_BIN_FACTOR   = 4'd2;
    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd4096;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd4096;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_NONE  = 2'd0;
    localparam kind_t KIND_PASS  = 2'd1;
    localparam kind_t KIND_STORE = 2'd2;
    localparam kind_t KIND_AVG   = 2'd3;

    typedef struct packed {
        logic accept;
        logic mem_wr;
        logic div_start;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        kind_t kind;
        kind_t kind_held;
        logic  div_done;
        logic  out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

/* src/ibba_div.sv */
// Restoring divider, one quotient bit per cycle
`default_nettype none

module ibba_div #(
    parameter int DW = 22,
    parameter int VW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic      [DW-1:0] quotient,
    output logic               done
);

    localparam int CNT_W = $clog2(DW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [VW-1:0]    rem_reg;
    logic [DW-1:0]    quo_reg;
    logic [VW-1:0]    dvs_reg;

    logic [VW:0]      shifted;
    logic [VW+1:0]    trial;
    logic             ge;

    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};
    assign ge      = !trial[VW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            done_reg <= (cnt_reg == CNT_W'(1));
            busy_reg <= (cnt_reg != CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? trial[VW-1:0] : shifted[VW-1:0];
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

/* src/ibba_datapath.sv */
// Binning datapath: config registers, frame position, line store, divider, output word
`default_nettype none

module ibba_datapath #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_BIN    = 8,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ibba_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [ibba_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic [ibba_pkg::PIX_W-1:0]     pixel_in,
    input  wire logic                           out_stall,
    output logic                                out_valid,
    output logic      [ibba_pkg::PIX_W-1:0]     pixel_out,
    output logic                                line_end,
    output logic                                frame_end,
    input  wire ibba_pkg::ctl_cmd_t             cmd,
    output ibba_pkg::dp_sts_t                   sts
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int EW    = CW + 1;
    localparam int XW    = ((EW > ibba_pkg::BIN_W) ? EW : ibba_pkg::BIN_W) + 1;
    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = $clog2(MAX_BIN);
    localparam int ROW_W = PIXEL_BITS + IW;
    localparam int SUM_W = PIXEL_BITS + 2 * IW;
    localparam int VW    = 2 * ibba_pkg::BIN_W;
    localparam int BW    = ibba_pkg::BIN_W;
    localparam int RX    = ibba_pkg::RX_W;

    // configuration
    logic [BW-1:0]                    bin_reg;
    logic [ibba_pkg::CFG_W-1:0]       width_reg;
    logic [ibba_pkg::CFG_W-1:0]       height_reg;
    logic                             restart;

    // frame position
    logic [CW-1:0]                    col_reg,     col_next;
    logic [ibba_pkg::ROW_CNT_W-1:0]   row_reg,     row_next;
    logic [IW-1:0]                    cib_reg,     cib_next;
    logic [IW-1:0]                    rib_reg,     rib_next;
    logic [AW-1:0]                    out_col_reg, out_col_next;
    logic [ROW_W-1:0]                 row_sum_reg, row_sum_next;

    // held word
    ibba_pkg::kind_t                  kind_reg;
    logic [ROW_W-1:0]                 seg_reg;
    logic [ibba_pkg::PIX_W-1:0]       pix_reg;
    logic                             first_row_reg;
    logic [AW-1:0]                    idx_reg;
    logic [SUM_W-1:0]                 rd_data_reg;
    logic                             lend_reg;
    logic                             fend_reg;

    // output word
    logic                             out_valid_reg;
    logic [ibba_pkg::PIX_W-1:0]       pixel_out_reg;
    logic                             line_end_reg;
    logic                             frame_end_reg;

    logic [SUM_W-1:0]                 mem [DEPTH];

    logic [BW-1:0]                    b_eff;
    logic                             binning;
    logic [EW-1:0]                    w_eff;
    logic [ibba_pkg::HGT_W-1:0]       h_eff;
    logic [XW-1:0]                    col_x, cib_x, b_x, w_x;
    logic [RX-1:0]                    row_x, rib_x, b_r, h_x;
    logic                             in_col, in_row, blk_end, rib_last;
    logic                             col_last, row_last, lend_avg, fend_avg;
    logic                             in_range;
    ibba_pkg::kind_t                  kind_now;
    logic [ibba_pkg::PIX_W-1:0]       pix_m;
    logic [ROW_W-1:0]                 row_add;
    logic [SUM_W-1:0]                 total;
    logic [SUM_W-1:0]                 quotient;
    logic                             div_done;
    logic                             out_free;

    assign restart = cfg_wr_en && ((cfg_index == ibba_pkg::REG_BIN_FACTOR) ||
                                   (cfg_index == ibba_pkg::REG_FRAME_WIDTH) ||
                                   (cfg_index == ibba_pkg::REG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_reg    <= ibba_pkg::RST_BIN_FACTOR;
            width_reg  <= ibba_pkg::RST_FRAME_WIDTH;
            height_reg <= ibba_pkg::RST_FRAME_HEIGHT;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                ibba_pkg::REG_BIN_FACTOR:   bin_reg    <= cfg_data[BW-1:0];
                ibba_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                ibba_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        b_eff = (32'(bin_reg) > 32'(MAX_BIN)) ? BW'(MAX_BIN) : bin_reg;
        binning = (32'(b_eff) >= 32'(ibba_pkg::MIN_BIN));
        if (width_reg == '0)
            w_eff = EW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_eff = EW'(MAX_WIDTH);
        else
            w_eff = EW'(width_reg);
        if (height_reg == '0)
            h_eff = ibba_pkg::HGT_W'(1);
        else if (32'(height_reg) > 32'(ibba_pkg::HEIGHT_LIMIT))
            h_eff = ibba_pkg::HGT_W'(ibba_pkg::HEIGHT_LIMIT);
        else
            h_eff = height_reg;
    end

    assign col_x = XW'(col_reg);
    assign cib_x = XW'(cib_reg);
    assign b_x   = XW'(b_eff);
    assign w_x   = XW'(w_eff);
    assign row_x = RX'(row_reg);
    assign rib_x = RX'(rib_reg);
    assign b_r   = RX'(b_eff);
    assign h_x   = RX'(h_eff);

    assign in_col   = (col_x - cib_x + b_x) <= w_x;
    assign in_row   = (row_x - rib_x + b_r) <= h_x;
    assign blk_end  = BW'(cib_reg) == (b_eff - BW'(1));
    assign rib_last = BW'(rib_reg) == (b_eff - BW'(1));
    assign col_last = (col_x + XW'(1)) >= w_x;
    assign row_last = (row_x + RX'(1)) >= h_x;
    assign lend_avg = (col_x + XW'(1) + b_x) > w_x;
    assign fend_avg = (row_x + RX'(1) + b_r) > h_x;
    assign in_range = binning && in_col && in_row;

    always_comb
    begin
        if (!binning)
            kind_now = ibba_pkg::KIND_PASS;
        else if (in_range && blk_end)
            kind_now = rib_last ? ibba_pkg::KIND_AVG : ibba_pkg::KIND_STORE;
        else
            kind_now = ibba_pkg::KIND_NONE;
    end

    assign pix_m   = ibba_pkg::PIX_W'(pixel_in[PIXEL_BITS-1:0]);
    assign row_add = row_sum_reg + ROW_W'(pix_m);

    always_comb
    begin
        row_sum_next = row_sum_reg;
        if (in_range)
            row_sum_next = blk_end ? '0 : row_add;
        cib_next     = (!binning || blk_end) ? '0 : cib_reg + IW'(1);
        out_col_next = (binning && blk_end) ? out_col_reg + AW'(1) : out_col_reg;
        col_next     = col_reg + CW'(1);
        rib_next     = rib_reg;
        row_next     = row_reg;
        if (col_last)
        begin
            row_sum_next = '0;
            cib_next     = '0;
            out_col_next = '0;
            col_next     = '0;
            rib_next     = (!binning || rib_last) ? '0 : rib_reg + IW'(1);
            row_next     = row_reg + ibba_pkg::ROW_CNT_W'(1);
            if (row_last)
            begin
                rib_next = '0;
                row_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            cib_reg     <= '0;
            rib_reg     <= '0;
            out_col_reg <= '0;
            row_sum_reg <= '0;
            kind_reg    <= ibba_pkg::KIND_NONE;
        end
        else if (restart)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            cib_reg     <= '0;
            rib_reg     <= '0;
            out_col_reg <= '0;
            row_sum_reg <= '0;
        end
        else if (cmd.accept)
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            cib_reg     <= cib_next;
            rib_reg     <= rib_next;
            out_col_reg <= out_col_next;
            row_sum_reg <= row_sum_next;
            kind_reg    <= kind_now;
        end
    end

    // hold the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            seg_reg       <= row_add;
            pix_reg       <= pix_m;
            first_row_reg <= (rib_reg == '0);
            idx_reg       <= out_col_reg;
            lend_reg      <= binning ? lend_avg : col_last;
            fend_reg      <= binning ? (lend_avg && fend_avg) : (col_last && row_last);
        end
    end

    assign total = SUM_W'(seg_reg) + (first_row_reg ? '0 : rd_data_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            rd_data_reg <= mem[out_col_reg];
        if (cmd.mem_wr)
            mem[idx_reg] <= total;
    end

    ibba_div #(
        .DW (SUM_W),
        .VW (VW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (total),
        .divisor  (VW'(b_eff) * VW'(b_eff)),
        .quotient (quotient),
        .done     (div_done)
    );

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            pixel_out_reg <= (kind_reg == ibba_pkg::KIND_PASS) ? pix_reg
                                                               : ibba_pkg::PIX_W'(quotient);
            line_end_reg  <= lend_reg;
            frame_end_reg <= fend_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign line_end  = line_end_reg;
    assign frame_end = frame_end_reg;

    assign sts.kind      = kind_now;
    assign sts.kind_held = kind_reg;
    assign sts.div_done  = div_done;
    assign sts.out_free  = out_free;

endmodule

`default_nettype wire

/* src/ibba_ctrl.sv */
// Binning controller: sequences accept, line store write, divide and output load
`default_nettype none

`include "image_block_binning_average_unit_macros.svh"

module ibba_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire ibba_pkg::dp_sts_t   sts,
    output ibba_pkg::ctl_cmd_t       cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SUM  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    case (sts.kind)
                        ibba_pkg::KIND_PASS:  state_next = S_EMIT;
                        ibba_pkg::KIND_STORE: state_next = S_SUM;
                        ibba_pkg::KIND_AVG:   state_next = S_SUM;
                        default:              state_next = S_IDLE;
                    endcase
                end
            end
            S_SUM:
            begin
                if (sts.kind_held == ibba_pkg::KIND_AVG)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.mem_wr = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

    `IBBA_ASSERT_IMP(a_load_when_free, clk, rst_n, cmd.load_out, sts.out_free)
    `IBBA_ASSERT_NXT(a_div_to_emit, clk, rst_n, (state_reg == S_DIV) && sts.div_done, state_reg == S_EMIT)
    `IBBA_ASSERT_NXT(a_start_no_done, clk, rst_n, cmd.div_start, (state_reg == S_DIV) && !sts.div_done)
    `IBBA_ASSERT_NXT(a_store_to_idle, clk, rst_n, cmd.mem_wr, state_reg == S_IDLE)

endmodule

`default_nettype wire

/* src/image_block_binning_average_unit.sv */
// Top level of the pixel binning unit: N x N truncated-mean binning of a raster stream
//
// Pixels enter on in_valid/in_stall/pixel_in in raster order; binned pixels leave on
// out_valid/out_stall/pixel_out with line_end and frame_end marking the last word of
// an output line and of the frame. A word moves when valid is high and stall is low.
// Configuration (bin factor, frame width, frame height) is written through
// cfg_wr_en/cfg_index/cfg_data while the unit is idle; a write to any of these three
// restarts the frame. A pixel that does not close a block leaves the controller idle.
// A pixel that closes a block in an upper row of its band stalls the input for the
// line store write, the read having been made as the pixel was taken. A pixel that
// closes a whole block stalls the input while its sum goes through a restoring
// divider that resolves one quotient bit per cycle. In pass-through mode (bin factor
// below 2) each pixel goes straight to the output register. A stalled result holds
// in the output register; the unit still takes pixels that produce no result, and
// stalls its input once the next result is ready. Reset clears the position counters
// and restores the register defaults; the line store needs no clearing, each entry
// is written before it is read.
`default_nettype none

module image_block_binning_average_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_BIN    = 8,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [ibba_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [ibba_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [ibba_pkg::PIX_W-1:0]  pixel_in,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [ibba_pkg::PIX_W-1:0]  pixel_out,
    output logic                             line_end,
    output logic                             frame_end
);

    ibba_pkg::ctl_cmd_t cmd;
    ibba_pkg::dp_sts_t  sts;

    ibba_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_BIN    (MAX_BIN),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel_in  (pixel_in),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .pixel_out (pixel_out),
        .line_end  (line_end),
        .frame_end (frame_end),
        .cmd       (cmd),
        .sts       (sts)
    );

    ibba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

endmodule

`default_nettype wire
